/* rtl/bcr_pkg.sv */
package bcr_pkg;

    localparam int MAX_SRC_WIDTH  = 512;
    localparam int MAX_SRC_HEIGHT = 512;
    localparam int FRACTION_BITS  = 16;
    localparam int STEP_FRAC      = 16;
    localparam int XW = $clog2(MAX_SRC_WIDTH);
    localparam int YW = $clog2(MAX_SRC_HEIGHT);
    localparam int AW = XW + YW;
    // sample width: pixel Q8.F plus headroom for overshoot
    localparam int SW = FRACTION_BITS + 14;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] REG_STEP_X     = 2'd2;
    localparam logic [1:0] REG_STEP_Y     = 2'd3;

    typedef struct packed {
        logic        operation;
        logic [11:0] coord_x;
        logic [11:0] coord_y;
        logic [7:0]  pixel_in;
    } in_item_t;

    typedef struct packed {
        logic [11:0] out_x;
        logic [11:0] out_y;
        logic [7:0]  pixel_out;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [23:0] data;
    } cfg_item_t;

    // interpolator control from the sequencer
    typedef struct packed {
        logic       start;
        logic       load;
        logic [1:0] slot;
        logic       col_pass;
    } interp_ctl_t;

endpackage

/* rtl/bcr_src_mem.sv */
module bcr_src_mem (
    input  logic                 clk,
    input  logic                 we,
    input  logic [bcr_pkg::AW-1:0] waddr,
    input  logic [7:0]           wdata,
    input  logic                 re,
    input  logic [bcr_pkg::AW-1:0] raddr,
    output logic [7:0]           rdata
);

    logic [7:0] mem [0:(1 << bcr_pkg::AW)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/bcr_interp.sv */
// One Catmull-Rom pass over four held samples, one multiply per cycle.
module bcr_interp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bcr_pkg::interp_ctl_t       ctl,
    input  logic signed [bcr_pkg::SW-1:0] sample,
    input  logic [bcr_pkg::FRACTION_BITS-1:0] t,
    output logic                       done,
    output logic signed [bcr_pkg::SW-1:0] result
);

    localparam int F  = bcr_pkg::FRACTION_BITS;
    localparam int SW = bcr_pkg::SW;
    localparam int PW = SW + F + 5;

    logic signed [SW-1:0] p_reg [0:3];
    logic signed [SW+3:0] acc_reg, acc_next;
    logic [3:0]           phase_reg, phase_next;
    logic                 done_reg, done_next;
    logic signed [SW-1:0] result_reg, result_next;
    logic signed [PW-1:0] prod;
    logic signed [SW+3:0] d0, d1, d2;

    always_comb
    begin
        d0 = 3 * ($signed({{4{p_reg[1][SW-1]}}, p_reg[1]}) - p_reg[2]) + p_reg[3] - p_reg[0];
        d1 = 2 * $signed({{4{p_reg[0][SW-1]}}, p_reg[0]}) - 5 * p_reg[1]
             + 4 * p_reg[2] - p_reg[3];
        d2 = $signed({{4{p_reg[2][SW-1]}}, p_reg[2]}) - p_reg[0];
        prod = $signed({1'b0, t}) * acc_reg;
        acc_next    = acc_reg;
        phase_next  = phase_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        priority case (1'b1)
            ctl.start:
            begin
                acc_next   = d0;
                phase_next = 4'b0001;
            end
            phase_reg[0]:
            begin
                acc_next   = d1 + (SW+4)'(prod >>> F);
                phase_next = 4'b0010;
            end
            phase_reg[1]:
            begin
                acc_next   = d2 + (SW+4)'(prod >>> F);
                phase_next = 4'b0100;
            end
            phase_reg[2]:
            begin
                result_next = SW'(p_reg[1] + (prod >>> (F + 1)));
                done_next   = 1'b1;
                phase_next  = 4'b0000;
            end
            default:
            begin
                phase_next = 4'b0000;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            p_reg[ctl.slot] <= sample;
        end
        acc_reg    <= acc_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 4'b0000;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* rtl/bicubic_resize.sv */
// Load transfer: taken with no result; in_ready stays high for the next item.
// Request: out_valid rises after four rows of four reads, each row followed by its
// row pass, then a column pass and a final step into the output register.
// One request at a time; the next item is taken after the request's result is loaded
// into the output register; an earlier result that still waits there holds the handoff.
// Reset (rst_n, async low) clears control and restores size and step to 512, 512, 1.0, 1.0.
module bicubic_resize (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bcr_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output bcr_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  bcr_pkg::cfg_item_t cfg_data
);

    localparam int F  = bcr_pkg::FRACTION_BITS;
    localparam int SW = bcr_pkg::SW;
    localparam int XW = bcr_pkg::XW;
    localparam int YW = bcr_pkg::YW;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_ROW   = 5'b00100,
        S_COL   = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [9:0]  w_reg, h_reg;
    logic [23:0] sx_reg, sy_reg;
    logic [11:0] cx_reg, cy_reg;
    logic [35:0] px_reg, py_reg;
    logic [3:0]  cnt_reg, cnt_next;
    logic        rd_pend_reg;
    logic        row_go_reg;
    logic [3:0]  rd_idx_reg;
    logic [1:0]  row_reg, row_next;
    logic signed [SW-1:0] colv_reg [0:3];
    logic        out_valid_reg;
    bcr_pkg::out_item_t out_reg;

    logic [XW:0] w_eff;
    logic [YW:0] h_eff;
    always_comb
    begin
        w_eff = (w_reg == 10'd0) ? (XW+1)'(1)
              : (w_reg > 10'(bcr_pkg::MAX_SRC_WIDTH)) ? (XW+1)'(bcr_pkg::MAX_SRC_WIDTH)
              : (XW+1)'(w_reg);
        h_eff = (h_reg == 10'd0) ? (YW+1)'(1)
              : (h_reg > 10'(bcr_pkg::MAX_SRC_HEIGHT)) ? (YW+1)'(bcr_pkg::MAX_SRC_HEIGHT)
              : (YW+1)'(h_reg);
    end

    // neighbour address for read count
    logic signed [21:0] xs, ys;
    logic [XW-1:0] xx;
    logic [YW-1:0] yy;
    always_comb
    begin
        xs = $signed({1'b0, px_reg[35:16]}) + $signed({20'd0, cnt_reg[1:0]}) - 22'sd1;
        ys = $signed({1'b0, py_reg[35:16]}) + $signed({20'd0, cnt_reg[3:2]}) - 22'sd1;
        if (xs < 0)
            xx = '0;
        else if (xs > $signed({11'd0, w_eff}) - 22'sd1)
            xx = XW'(w_eff - 1'b1);
        else
            xx = XW'(xs);
        if (ys < 0)
            yy = '0;
        else if (ys > $signed({11'd0, h_eff}) - 22'sd1)
            yy = YW'(h_eff - 1'b1);
        else
            yy = YW'(ys);
    end

    logic accept_in, load_ok, mem_re;
    logic [7:0] rdata;
    assign in_ready  = (state_reg == S_IDLE);
    assign accept_in = in_valid && in_ready;
    assign load_ok   = accept_in && (in_data.operation == bcr_pkg::OP_LOAD)
                       && ({1'b0, in_data.coord_x} < 13'(w_eff))
                       && ({1'b0, in_data.coord_y} < 13'(h_eff));
    assign mem_re    = (state_reg == S_READ);

    bcr_src_mem u_mem (
        .clk   (clk),
        .we    (load_ok),
        .waddr ({in_data.coord_y[YW-1:0], in_data.coord_x[XW-1:0]}),
        .wdata (in_data.pixel_in),
        .re    (mem_re),
        .raddr ({yy, xx}),
        .rdata (rdata)
    );

    bcr_pkg::interp_ctl_t ctl;
    logic signed [SW-1:0] sample, result;
    logic [F-1:0] t;
    logic done;

    always_comb
    begin
        ctl = '0;
        sample = '0;
        if (state_reg == S_READ || state_reg == S_ROW)
        begin
            ctl.load = rd_pend_reg;
            ctl.slot = rd_idx_reg[1:0];
            sample   = $signed({{(SW-8-F){1'b0}}, rdata, {F{1'b0}}});
            // start once, the cycle after the last sample of the row lands
            ctl.start = (state_reg == S_ROW) && row_go_reg;
        end
        else if (state_reg == S_COL && cnt_reg < 4'd4)
        begin
            ctl.load = 1'b1;
            ctl.slot = cnt_reg[1:0];
            ctl.col_pass = 1'b1;
            sample = colv_reg[cnt_reg[1:0]];
        end
        else if (state_reg == S_COL && cnt_reg == 4'd4)
        begin
            ctl.start = 1'b1;
            ctl.col_pass = 1'b1;
        end
        t = (state_reg == S_COL) ? F'(py_reg[15:16-F]) : F'(px_reg[15:16-F]);
    end

    bcr_interp u_interp (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .sample (sample),
        .t      (t),
        .done   (done),
        .result (result)
    );

    // sequencer: read a row of four, run its pass, repeat; then column pass and output
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        row_next   = row_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept_in && in_data.operation == bcr_pkg::OP_REQUEST)
                begin
                    state_next = S_READ;
                    cnt_next   = 4'd0;
                    row_next   = 2'd0;
                end
            end
            S_READ:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg[1:0] == 2'd3)
                begin
                    state_next = S_ROW;
                end
            end
            S_ROW:
            begin
                if (done)
                begin
                    row_next = row_reg + 2'd1;
                    if (row_reg == 2'd3)
                    begin
                        state_next = S_COL;
                        cnt_next   = 4'd0;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_COL:
            begin
                if (cnt_reg < 4'd5)
                    cnt_next = cnt_reg + 4'd1;
                if (done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // hold cnt at row boundary so the row address keeps its row
    logic [3:0] cnt_q;
    assign cnt_q = (state_reg == S_ROW) ? cnt_reg : cnt_next;

    logic [7:0] pix;
    always_comb
    begin
        if (result < 0)
            pix = 8'd0;
        else if ((result >>> F) > 255)
            pix = 8'd255;
        else
            pix = 8'(result >>> F);
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            cx_reg <= in_data.coord_x;
            cy_reg <= in_data.coord_y;
            px_reg <= 36'(in_data.coord_x) * 36'(sx_reg);
            py_reg <= 36'(in_data.coord_y) * 36'(sy_reg);
        end
        rd_idx_reg <= cnt_reg;
        if (state_reg == S_ROW && done)
        begin
            colv_reg[row_reg] <= result;
        end
        // load the output only once the previous transfer has gone
        if (state_reg == S_OUT && (!out_valid_reg || out_ready))
        begin
            out_reg.out_x     <= cx_reg;
            out_reg.out_y     <= cy_reg;
            out_reg.pixel_out <= pix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= 4'd0;
            row_reg       <= 2'd0;
            rd_pend_reg   <= 1'b0;
            row_go_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            w_reg         <= 10'd512;
            h_reg         <= 10'd512;
            sx_reg        <= 24'd65536;
            sy_reg        <= 24'd65536;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_q;
            row_reg     <= row_next;
            rd_pend_reg <= mem_re;
            row_go_reg  <= (state_reg == S_ROW) && rd_pend_reg;
            if (state_reg == S_OUT && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cfg_valid)
            begin
                unique case (cfg_data.index)
                    bcr_pkg::REG_SRC_WIDTH:  w_reg  <= cfg_data.data[9:0];
                    bcr_pkg::REG_SRC_HEIGHT: h_reg  <= cfg_data.data[9:0];
                    bcr_pkg::REG_STEP_X:     sx_reg <= cfg_data.data;
                    bcr_pkg::REG_STEP_Y:     sy_reg <= cfg_data.data;
                    default: ;
                endcase
            end
        end
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* test/bicubic_resize_tb.sv */
`default_nettype none

module bicubic_resize_tb;
    import bcr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IMG_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 60;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    cfg_item_t cfg_data = '0;

    bicubic_resize u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // pending input items and pixels expected back
    in_item_t  pend_q[$];
    out_item_t pixel_exp_q[$];
    int        mismatches = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;

    // predictor copy of the block
    bit [7:0]  pred_img [0:IMG_DEPTH-1];
    int        pred_w = 512;
    int        pred_h = 512;
    longint    pred_sx = 65536;
    longint    pred_sy = 65536;

    // stimulus-side view, to keep every read pixel written
    bit        gen_written [0:IMG_DEPTH-1];
    int        gen_w = 512;
    int        gen_h = 512;
    longint    gen_sx = 65536;
    longint    gen_sy = 65536;

    logic      hold_req = 1'b0;
    logic      hold_armed = 1'b0;
    int        hold_cnt = 0;

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #30ms;
        $display("bicubic_resize_tb failed");
        $finish;
    end

    function automatic int eff_size(int v);
        if (v == 0)
            return 1;
        return (v > 512) ? 512 : v;
    endfunction

    function automatic int clamp_idx(longint v, int last);
        if (v < 0)
            return 0;
        return (v > last) ? last : int'(v);
    endfunction

    function automatic longint catmull_rom(longint p0, longint p1, longint p2, longint p3,
                                           longint t);
        longint d0, d1, d2, a, b;
        d0 = 3 * (p1 - p2) + p3 - p0;
        d1 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        d2 = p2 - p0;
        a = d1 + ((t * d0) >>> FRACTION_BITS);
        b = d2 + ((t * a) >>> FRACTION_BITS);
        return p1 + ((t * b) >>> (FRACTION_BITS + 1));
    endfunction

    function automatic bit [7:0] interp_pixel(int cx, int cy);
        longint px, py, xi, yi, tx, ty, v;
        longint s [4];
        longint c [4];
        int     w, h, yy, xx;
        w = eff_size(pred_w);
        h = eff_size(pred_h);
        px = longint'(cx) * pred_sx;
        py = longint'(cy) * pred_sy;
        xi = px >> STEP_FRAC;
        yi = py >> STEP_FRAC;
        tx = px & 64'hFFFF;
        ty = py & 64'hFFFF;
        for (int i = 0; i < 4; i++)
        begin
            yy = clamp_idx(yi + i - 1, h - 1);
            for (int j = 0; j < 4; j++)
            begin
                xx = clamp_idx(xi + j - 1, w - 1);
                s[j] = longint'(pred_img[yy * MAX_SRC_WIDTH + xx]) << FRACTION_BITS;
            end
            c[i] = catmull_rom(s[0], s[1], s[2], s[3], tx);
        end
        v = catmull_rom(c[0], c[1], c[2], c[3], ty);
        if (v < 0)
            return 8'd0;
        v = v >>> FRACTION_BITS;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    // sender: advance to the next pending item once the current one transfers
    always @(posedge clk)
    begin
        logic     nxt_valid;
        in_item_t nxt_data;
        nxt_valid = in_valid;
        nxt_data = in_data;
        if (rst_n && (!in_valid || in_ready))
        begin
            nxt_valid = 1'b0;
            if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt_valid = 1'b1;
                nxt_data = pend_q.pop_front();
            end
        end
        in_valid <= nxt_valid;
        in_data <= nxt_data;
    end

    always @(posedge clk)
    begin
        if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
        else if (hold_req && !hold_armed)
        begin
            hold_cnt <= HOLD_CYCLES;
            hold_armed <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= rst_n && (hold_cnt == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    // check results, then predict from accepted items and register writes
    always @(posedge clk)
    begin
        out_item_t want;
        if (out_valid && out_ready)
        begin
            if (pixel_exp_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%0d y=%0d pixel=%0d",
                             out_data.out_x, out_data.out_y, out_data.pixel_out);
            end
            else
            begin
                want = pixel_exp_q.pop_front();
                if (out_data !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected x=%0d y=%0d pixel=%0d, got x=%0d y=%0d pixel=%0d",
                                 want.out_x, want.out_y, want.pixel_out,
                                 out_data.out_x, out_data.out_y, out_data.pixel_out);
                end
            end
        end
        if (in_valid && in_ready)
        begin
            if (in_data.operation == OP_LOAD)
            begin
                if (in_data.coord_x < eff_size(pred_w) && in_data.coord_y < eff_size(pred_h))
                    pred_img[in_data.coord_y * MAX_SRC_WIDTH + in_data.coord_x] = in_data.pixel_in;
            end
            else
            begin
                want.out_x = in_data.coord_x;
                want.out_y = in_data.coord_y;
                want.pixel_out = interp_pixel(in_data.coord_x, in_data.coord_y);
                pixel_exp_q.push_back(want);
            end
        end
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_data.index)
                REG_SRC_WIDTH:  pred_w = cfg_data.data[9:0];
                REG_SRC_HEIGHT: pred_h = cfg_data.data[9:0];
                REG_STEP_X:     pred_sx = cfg_data.data;
                REG_STEP_Y:     pred_sy = cfg_data.data;
                default:        ;
            endcase
        end
    end

    task automatic queue_load(int x, int y, int p);
        in_item_t it;
        it.operation = OP_LOAD;
        it.coord_x = x[11:0];
        it.coord_y = y[11:0];
        it.pixel_in = p[7:0];
        pend_q.push_back(it);
        if (x < eff_size(gen_w) && y < eff_size(gen_h))
            gen_written[y * MAX_SRC_WIDTH + x] = 1'b1;
    endtask

    // write any unwritten neighbor first so no read hits an empty entry
    task automatic queue_request(int x, int y);
        in_item_t it;
        longint   xi, yi;
        int       xx, yy;
        xi = (longint'(x) * gen_sx) >> STEP_FRAC;
        yi = (longint'(y) * gen_sy) >> STEP_FRAC;
        for (int i = 0; i < 4; i++)
        begin
            yy = clamp_idx(yi + i - 1, eff_size(gen_h) - 1);
            for (int j = 0; j < 4; j++)
            begin
                xx = clamp_idx(xi + j - 1, eff_size(gen_w) - 1);
                if (!gen_written[yy * MAX_SRC_WIDTH + xx])
                    queue_load(xx, yy, $urandom_range(255));
            end
        end
        it.operation = OP_REQUEST;
        it.coord_x = x[11:0];
        it.coord_y = y[11:0];
        it.pixel_in = $urandom_range(255);
        pend_q.push_back(it);
    endtask

    task automatic write_reg(logic [1:0] idx, int value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data.index <= idx;
        cfg_data.data <= value[23:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SRC_WIDTH:  gen_w = value & 'h3FF;
            REG_SRC_HEIGHT: gen_h = value & 'h3FF;
            REG_STEP_X:     gen_sx = value & 'hFFFFFF;
            REG_STEP_Y:     gen_sy = value & 'hFFFFFF;
            default:        ;
        endcase
    endtask

    task automatic configure(int w, int h, int sx, int sy);
        write_reg(REG_SRC_WIDTH, w);
        write_reg(REG_SRC_HEIGHT, h);
        write_reg(REG_STEP_X, sx);
        write_reg(REG_STEP_Y, sy);
    endtask

    task automatic drain();
        while (pend_q.size() != 0 || in_valid || pixel_exp_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_items(int n, int reach);
        int r, lx, ly;
        repeat (n)
        begin
            r = $urandom_range(99);
            lx = ((eff_size(gen_w) < reach) ? eff_size(gen_w) : reach) - 1;
            ly = ((eff_size(gen_h) < reach) ? eff_size(gen_h) : reach) - 1;
            if (r < 5)
                queue_load($urandom_range(4095), $urandom_range(4095), $urandom_range(255));
            else if (r < 35)
                queue_load($urandom_range(lx), $urandom_range(ly), $urandom_range(255));
            else if (r < 92)
                queue_request($urandom_range(reach), $urandom_range(reach));
            else
                queue_request($urandom_range(4095), $urandom_range(4095));
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: edge pixels, ignored loads, far requests
        queue_load(0, 0, 0);
        queue_load(511, 511, 255);
        queue_load(1, 0, 255);
        queue_load(0, 1, 255);
        queue_load(512, 0, 77);
        queue_load(0, 512, 77);
        queue_load(4095, 4095, 77);
        queue_request(0, 0);
        queue_request(1, 1);
        queue_request(4095, 4095);
        queue_request(510, 510);
        queue_request(4095, 0);
        queue_request(0, 4095);
        drain();

        // 2x upscale-ish; hold off the receiver so the input stalls
        configure(8, 6, 'h8000, 'h6000);
        for (int y = 0; y < 6; y++)
            for (int x = 0; x < 8; x++)
                queue_load(x, y, ((x + y) & 1) ? 255 : 0);
        queue_request(3, 3);
        queue_request(15, 11);
        hold_req <= 1'b1;
        random_items(120, 20);
        drain();

        // size zero and oversize, zero and max step; sender idles
        send_idle_pct = 62;
        configure(0, 1023, 0, 'hFFFFFF);
        queue_request(4095, 4095);
        queue_request(0, 1);
        random_items(110, 30);
        drain();

        // receiver stalls; sender pauses midway until all results are back
        send_idle_pct = 0;
        recv_stall_pct = 62;
        configure(5, 7, 'h18000, 'h5555);
        random_items(60, 25);
        drain();
        random_items(60, 25);
        drain();

        send_idle_pct = 15;
        recv_stall_pct = 15;
        configure(16, 16, $urandom_range(1, 'h3FFFF), $urandom_range(1, 'h3FFFF));
        random_items(110, 40);
        drain();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        configure(4, 4, 1, 'h30000);
        random_items(110, 12);
        drain();

        if (mismatches == 0)
            $display("bicubic_resize_tb passed");
        else
            $display("bicubic_resize_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
